/* rtl/core/ssrcl_pkg.sv */
// Shared types and constants for the shared RAM with undo log.
package ssrcl_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int ADDR_BITS = $clog2(MEM_BYTES);
	localparam int MAX_ACCESS_BYTES = 4;
	localparam int TIME_BITS = 48;
	localparam int REQUESTER_BITS = 8;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_PEEK     = 3'd2,
		OP_POKE     = 3'd3,
		OP_LOCK     = 3'd4,
		OP_UNLOCK   = 3'd5,
		OP_COMMIT   = 3'd6,
		OP_ROLLBACK = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [11:0] address;
		logic [2:0]  byte_count;
		logic [31:0] write_data;
		logic [7:0]  requester;
		logic [47:0] access_time;
		logic [15:0] access_context;
		logic [12:0] range_length;
	} in_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [1:0]  byte_index;
		logic        rollback_request;
		logic [7:0]  rollback_requester;
		logic [47:0] rollback_time;
		logic [15:0] rollback_context;
		logic        last;
	} out_t;

	// log entry as kept in memory
	typedef struct packed {
		logic                      written;
		logic                      shared;
		logic [7:0]                old_byte;
		logic [REQUESTER_BITS-1:0] requester;
		logic [TIME_BITS-1:0]      time_val;
		logic [15:0]               context_tag;
	} log_entry_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_OUT,
		ST_SWEEP,
		ST_CLR,
		ST_RB_RD,
		ST_RB_WR
	} state_t;

endpackage

/* rtl/core/speculative_shared_ram_conflict_log.sv */
// Shared byte RAM with undo log for speculative accesses.
// Channels: request in (in_valid/in_stall/in_data) and result out
// (out_valid/out_stall/out_data), both valid and stall handshakes.
// Read, write, peek and poke give one result per byte (byte_count above 4
// saturates to 4, zero gives none); last marks the final one. Each byte
// goes through a memory read, a log update and a result load in the
// single-port RAM, lock, log-valid and log memories; in_stall stays high
// until the result of the last byte is loaded into the output register.
// Lock and unlock walk range_length bytes (saturated to 4096), one a cycle.
// Commit clears the 4096 log-valid entries one a cycle; rollback walks all
// 4096 entries, reading each, restoring its logged byte if valid and clearing it.
// A result waits in the output register while out_stall is high; the next
// byte then waits for the register and the input stays stalled.
// After reset a clearing pass over all 4096 entries zeroes RAM, locks and log
// validity; in_stall stays high until it ends.
module speculative_shared_ram_conflict_log
	import ssrcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);
	logic [7:0]  ram_mem  [MEM_BYTES];
	logic        lock_mem [MEM_BYTES];
	logic        lv_mem   [MEM_BYTES];
	log_entry_t  log_mem  [MEM_BYTES];

	state_t state_q, state_d;
	in_t req_q;
	logic [2:0] n_q;
	logic [2:0] i_q;
	logic [ADDR_BITS:0] cnt_q;
	logic [ADDR_BITS-1:0] pos, maddr;
	logic [1:0] lane;
	logic [7:0] ram_rd_q;
	log_entry_t log_rd_q;
	logic lv_rd_q, lock_rd_q;
	log_entry_t next_entry;
	logic rollback;
	logic [7:0] wb, new_byte;
	logic tracked, is_wr, walk, cnt_end, out_load;
	out_t out_q;
	logic out_valid_q;
	logic [ADDR_BITS:0] len_sat;

	assign pos = req_q.address + ADDR_BITS'(i_q);
	assign walk = state_q inside {ST_INIT, ST_CLR, ST_RB_RD, ST_RB_WR};
	assign maddr = walk ? cnt_q[ADDR_BITS-1:0] : pos;
	assign cnt_end = (cnt_q == (ADDR_BITS+1)'(MEM_BYTES - 1));
	assign lane = 2'(n_q - 3'd1 - i_q);
	assign wb = req_q.write_data[{lane, 3'b000} +: 8];
	assign is_wr = (req_q.operation == OP_WRITE);
	assign tracked = (req_q.operation == OP_READ) || (is_wr && !lock_rd_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	ssrcl_track u_track (
		.valid_in      (lv_rd_q),
		.entry         (log_rd_q),
		.is_write      (is_wr),
		.cur_byte      (ram_rd_q),
		.requester     (req_q.requester),
		.access_time   (req_q.access_time),
		.access_context(req_q.access_context),
		.next_entry    (next_entry),
		.rollback      (rollback)
	);

	always_comb begin
		new_byte = ram_rd_q;
		if ((is_wr && !lock_rd_q) || req_q.operation == OP_POKE) new_byte = wb;
	end

	always_comb begin
		len_sat = (in_data.range_length > 13'(MEM_BYTES)) ? (ADDR_BITS+1)'(MEM_BYTES)
			: (ADDR_BITS+1)'(in_data.range_length);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (cnt_end) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(in_data.operation))
						OP_LOCK, OP_UNLOCK: state_d = (len_sat == '0) ? ST_IDLE : ST_SWEEP;
						OP_COMMIT: state_d = ST_CLR;
						OP_ROLLBACK: state_d = ST_RB_RD;
						default: state_d = (in_data.byte_count == 3'd0) ? ST_IDLE : ST_RD;
					endcase
				end
			end
			ST_RD: state_d = ST_UPD;
			ST_UPD: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load)
					state_d = (i_q + 3'd1 == n_q) ? ST_IDLE : ST_RD;
			end
			ST_SWEEP: if (cnt_q == (ADDR_BITS+1)'(1)) state_d = ST_IDLE;
			ST_CLR: if (cnt_end) state_d = ST_IDLE;
			ST_RB_RD: state_d = ST_RB_WR;
			ST_RB_WR: state_d = cnt_end ? ST_IDLE : ST_RB_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			out_valid_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_load | (out_valid_q & out_stall);
			case (state_q)
				ST_INIT, ST_CLR, ST_RB_WR: cnt_q <= cnt_q + 1'b1;
				ST_IDLE: begin
					i_q <= '0;
					if (in_valid) begin
						n_q <= (in_data.byte_count > 3'(MAX_ACCESS_BYTES)) ?
							3'(MAX_ACCESS_BYTES) : in_data.byte_count;
						cnt_q <= (in_data.operation inside {OP_LOCK, OP_UNLOCK}) ? len_sat : '0;
					end
				end
				ST_OUT: if (out_load) i_q <= i_q + 3'd1;
				ST_SWEEP: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// request register; sweep position: advance address through the range
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) req_q <= in_data;
		else if (state_q == ST_SWEEP) req_q.address <= req_q.address + 1'b1;
	end

	// memories and per-byte datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT: begin
				ram_mem[maddr] <= 8'd0;
				lock_mem[maddr] <= 1'b0;
				lv_mem[maddr] <= 1'b0;
			end
			ST_RD: begin
				ram_rd_q <= ram_mem[maddr];
				log_rd_q <= log_mem[maddr];
				lv_rd_q <= lv_mem[maddr];
				lock_rd_q <= lock_mem[maddr];
			end
			ST_UPD: begin
				if (tracked) begin
					log_mem[maddr] <= next_entry;
					lv_mem[maddr] <= 1'b1;
				end
				ram_mem[maddr] <= new_byte;
				out_q.read_byte <= new_byte;
				out_q.byte_index <= i_q[1:0];
				out_q.rollback_request <= tracked & rollback;
				out_q.rollback_requester <= (tracked & rollback) ? next_entry.requester : '0;
				out_q.rollback_time <= (tracked & rollback) ? next_entry.time_val : '0;
				out_q.rollback_context <= (tracked & rollback) ? next_entry.context_tag : '0;
				out_q.last <= (i_q + 3'd1 == n_q);
			end
			ST_SWEEP: lock_mem[maddr] <= (req_q.operation == OP_LOCK);
			ST_CLR: lv_mem[maddr] <= 1'b0;
			ST_RB_RD: begin
				log_rd_q <= log_mem[maddr];
				lv_rd_q <= lv_mem[maddr];
			end
			ST_RB_WR: begin
				// restore the logged byte if the entry is valid, and drop the entry
				if (lv_rd_q) ram_mem[maddr] <= log_rd_q.old_byte;
				lv_mem[maddr] <= 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data <= out_q;
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accepted while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data)) else $error("result changed");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (i_q < n_q)) else $error("byte index overrun");
`endif
endmodule

/* rtl/core/ssrcl_track.sv */
// Log update unit: merges one byte access into its log entry.
module ssrcl_track
	import ssrcl_pkg::*;
(
	input  logic                      valid_in,
	input  log_entry_t                entry,
	input  logic                      is_write,
	input  logic [7:0]                cur_byte,
	input  logic [REQUESTER_BITS-1:0] requester,
	input  logic [TIME_BITS-1:0]      access_time,
	input  logic [15:0]               access_context,
	output log_entry_t                next_entry,
	output logic                      rollback
);
	logic shared;

	always_comb begin
		next_entry = entry;
		rollback = 1'b0;
		shared = entry.shared | (entry.requester != requester);
		if (!valid_in) begin
			next_entry.written = is_write;
			next_entry.shared = 1'b0;
			next_entry.old_byte = cur_byte;
			next_entry.requester = requester;
			next_entry.time_val = access_time;
			next_entry.context_tag = access_context;
		end else begin
			next_entry.written = entry.written | is_write;
			next_entry.shared = shared;
			if (shared && access_time > entry.time_val) begin
				next_entry.time_val = access_time;
				next_entry.requester = requester;
			end
			rollback = shared & next_entry.written;
		end
	end
endmodule

/* sim/ssrcl_checker.sv */
`timescale 1ns / 100ps
// Checker for the shared RAM with undo log: predicts each result and compares.
module ssrcl_checker
	import ssrcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  out_t out_data,
	output int   errors,
	output int   pending
);

	logic [7:0]  mem_byte   [MEM_BYTES];
	logic        locked     [MEM_BYTES];
	logic        log_on     [MEM_BYTES];
	logic        log_wr     [MEM_BYTES];
	logic        log_sh     [MEM_BYTES];
	logic [7:0]  log_old    [MEM_BYTES];
	logic [7:0]  log_who    [MEM_BYTES];
	logic [47:0] log_stamp  [MEM_BYTES];
	logic [15:0] log_tag    [MEM_BYTES];
	out_t        result_q   [$];

	// log one tracked byte; returns 1 when a rollback is requested
	function automatic logic log_access(int p, logic wr, logic [7:0] who, logic [47:0] t,
			logic [15:0] tag);
		if (!log_on[p]) begin
			log_on[p]    = 1'b1;
			log_wr[p]    = wr;
			log_sh[p]    = 1'b0;
			log_old[p]   = mem_byte[p];
			log_who[p]   = who;
			log_stamp[p] = t;
			log_tag[p]   = tag;
			return 1'b0;
		end
		if (wr)
			log_wr[p] = 1'b1;
		if (log_who[p] != who)
			log_sh[p] = 1'b1;
		if (log_sh[p] && t > log_stamp[p]) begin
			log_stamp[p] = t;
			log_who[p]   = who;
		end
		return log_sh[p] && log_wr[p];
	endfunction

	task automatic predict_request(in_t r);
		int n;
		int p;
		int len;
		logic rb;
		logic [7:0] wb;
		out_t o;
		n = r.byte_count;
		case (op_t'(r.operation))
			OP_LOCK, OP_UNLOCK: begin
				len = (r.range_length > MEM_BYTES) ? MEM_BYTES : r.range_length;
				for (int k = 0; k < len; k++)
					locked[(r.address + k) % MEM_BYTES] = (r.operation == OP_LOCK);
			end
			OP_COMMIT: begin
				foreach (log_on[k]) log_on[k] = 1'b0;
			end
			OP_ROLLBACK: begin
				foreach (log_on[k]) begin
					if (log_on[k])
						mem_byte[k] = log_old[k];
					log_on[k] = 1'b0;
				end
			end
			default: begin
				if (n > MAX_ACCESS_BYTES)
					n = MAX_ACCESS_BYTES;
				for (int i = 0; i < n; i++) begin
					p  = (r.address + i) % MEM_BYTES;
					wb = 8'(r.write_data >> (8 * (n - 1 - i)));
					rb = 1'b0;
					if (r.operation == OP_READ)
						rb = log_access(p, 1'b0, r.requester, r.access_time, r.access_context);
					else if (r.operation == OP_WRITE) begin
						if (!locked[p]) begin
							rb = log_access(p, 1'b1, r.requester, r.access_time,
								r.access_context);
							mem_byte[p] = wb;
						end
					end else if (r.operation == OP_POKE)
						mem_byte[p] = wb;
					o.read_byte          = mem_byte[p];
					o.byte_index         = 2'(i);
					o.rollback_request   = rb;
					o.rollback_requester = rb ? log_who[p] : '0;
					o.rollback_time      = rb ? log_stamp[p] : '0;
					o.rollback_context   = rb ? log_tag[p] : '0;
					o.last               = (i + 1 == n);
					result_q.push_back(o);
				end
			end
		endcase
	endtask

	task automatic field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			foreach (mem_byte[k]) begin
				mem_byte[k] = '0;
				locked[k]   = 1'b0;
				log_on[k]   = 1'b0;
			end
			result_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, got %p", $time, out_data);
					errors++;
				end else begin
					e = result_q.pop_front();
					field_check("read_byte", e.read_byte, out_data.read_byte);
					field_check("byte_index", e.byte_index, out_data.byte_index);
					field_check("rollback_request", e.rollback_request,
						out_data.rollback_request);
					field_check("rollback_requester", e.rollback_requester,
						out_data.rollback_requester);
					field_check("rollback_time", e.rollback_time, out_data.rollback_time);
					field_check("rollback_context", e.rollback_context,
						out_data.rollback_context);
					field_check("last", e.last, out_data.last);
				end
			end
			if (in_valid && !in_stall)
				predict_request(in_data);
			pending = result_q.size();
		end
	end

endmodule

/* sim/speculative_shared_ram_conflict_log_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the shared RAM with undo log: stimulus and verdict.
module speculative_shared_ram_conflict_log_tb;
	import ssrcl_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	int   errors;
	int   pending;
	int   stall_left = 0;
	logic calm = 1'b0;
	logic [47:0] tick = 48'd100;

	speculative_shared_ram_conflict_log uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	ssrcl_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver: draw a stall length after each taken result
	always @(posedge clk)
		if (out_valid && !out_stall && stall_left == 0)
			stall_left = calm ? 0 : $urandom_range(0, 7);

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else
			out_stall <= 1'b0;
	end

	function automatic in_t req_of(op_t op, logic [11:0] a, logic [2:0] n, logic [31:0] d,
			logic [7:0] who, logic [47:0] t, logic [15:0] tag, logic [12:0] len);
		in_t r;
		r.operation      = op;
		r.address        = a;
		r.byte_count     = n;
		r.write_data     = d;
		r.requester      = who;
		r.access_time    = t;
		r.access_context = tag;
		r.range_length   = len;
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge after acceptance
	task automatic send(in_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic in_t random_request(logic [11:0] base);
		in_t r;
		int pick;
		if ($urandom_range(0, 99) < 15) begin
			r.operation      = 3'($urandom);
			r.address        = 12'($urandom);
			r.byte_count     = 3'($urandom);
			r.write_data     = $urandom;
			r.requester      = 8'($urandom);
			r.access_time    = 48'({$urandom, $urandom});
			r.access_context = 16'($urandom);
			r.range_length   = 13'($urandom);
			if (r.operation == OP_ROLLBACK && $urandom_range(0, 1))
				r.operation = OP_READ;
			return r;
		end
		tick = tick + $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		r.operation = pick < 30 ? OP_READ : pick < 65 ? OP_WRITE : pick < 70 ? OP_PEEK :
			pick < 75 ? OP_POKE : pick < 81 ? OP_LOCK : pick < 87 ? OP_UNLOCK :
			pick < 94 ? OP_COMMIT : OP_ROLLBACK;
		r.address        = 12'(base + $urandom_range(0, 15));
		r.byte_count     = 3'($urandom_range(1, 4));
		r.write_data     = $urandom;
		r.requester      = 8'($urandom_range(0, 3));
		// older stamps too, so the log time does not always move forward
		r.access_time    = $urandom_range(0, 3) == 0 ? tick - $urandom_range(0, 8) : tick;
		r.access_context = 16'($urandom);
		r.range_length   = 13'($urandom_range(0, 12));
		return r;
	endfunction

	initial begin
		in_t dir_q [$];
		logic [11:0] base;
		dir_q = '{
			req_of(OP_POKE, 12'd4094, 3'd4, 32'hAABBCCDD, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_PEEK, 12'd4094, 3'd4, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_READ, 12'd4094, 3'd4, 32'h0, 8'd1, 48'd10, 16'h1111, 13'd0),
			req_of(OP_WRITE, 12'd4095, 3'd2, 32'h55AA, 8'd2, 48'd20, 16'h2222, 13'd0),
			req_of(OP_READ, 12'd4095, 3'd1, 32'h0, 8'd1, 48'd5, 16'h3333, 13'd0),
			req_of(OP_LOCK, 12'd0, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd8191),
			req_of(OP_WRITE, 12'd100, 3'd4, 32'h12345678, 8'd3, 48'd30, 16'h4444, 13'd0),
			req_of(OP_UNLOCK, 12'd4000, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd4096),
			req_of(OP_WRITE, 12'd100, 3'd7, 32'hFFFFFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF,
				16'hFFFF, 13'h1FFF),
			req_of(OP_READ, 12'd100, 3'd0, 32'h0, 8'd1, 48'd40, 16'd0, 13'd0),
			req_of(OP_WRITE, 12'd101, 3'd2, 32'h0BAD, 8'd4, 48'd50, 16'h5555, 13'd0),
			req_of(OP_ROLLBACK, 12'd0, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_PEEK, 12'd4094, 3'd4, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_PEEK, 12'd100, 3'd5, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_WRITE, 12'd200, 3'd3, 32'h00C0FFEE, 8'd0, 48'd60, 16'h6666, 13'd0),
			req_of(OP_COMMIT, 12'd0, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_WRITE, 12'd200, 3'd3, 32'h00112233, 8'd1, 48'd70, 16'h7777, 13'd0),
			req_of(OP_LOCK, 12'd198, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd3),
			req_of(OP_WRITE, 12'd197, 3'd4, 32'hDEADBEEF, 8'd2, 48'd80, 16'h8888, 13'd0),
			req_of(OP_UNLOCK, 12'd198, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_ROLLBACK, 12'd0, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_PEEK, 12'd197, 3'd4, 32'h0, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_POKE, 12'd300, 3'd5, 32'h01020304, 8'd0, 48'd0, 16'd0, 13'd0),
			req_of(OP_UNLOCK, 12'd0, 3'd0, 32'h0, 8'd0, 48'd0, 16'd0, 13'd4096)
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_q[k])
			send(dir_q[k]);
		// hold off until every expected result is back
		drain();
		base = $urandom_range(0, 4095);
		for (int k = 0; k < 320; k++) begin
			if (k % 40 == 0)
				base = $urandom_range(0, 4095);
			calm = ((k / 60) % 3 == 1);
			send(random_request(base));
		end
		calm = 1'b0;
		drain();
		// a trailing rollback or lock walk gives no result; let it finish
		repeat (10000) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
